// ===== hdl/nmea_sentence_checker_unit_macros.svh =====
// Assertion macros shared by the checker of the NMEA sentence checker unit.
// Depends on nothing; included by the checker file only.
`ifndef NMEA_SENTENCE_CHECKER_UNIT_MACROS_SVH
`define NMEA_SENTENCE_CHECKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define NSC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("nmea checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is held.
`define NSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("nmea checker: next-cycle property failed");

`endif

// ===== hdl/nmea_chk_pkg.sv =====
// Shared types and constants of the NMEA sentence checker.
// Used by the core, the top level and the checker; depends on nothing.
package nmea_chk_pkg;

  localparam int NUM_TYPES = 4;
  localparam int NAME_LEN  = 5;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // Candidate type fields: GPGGA, GNGGA, GPRMC, GNRMC.
  localparam logic [7:0] TYPE_NAMES [NUM_TYPES][NAME_LEN] = '{
    '{8'h47, 8'h50, 8'h47, 8'h47, 8'h41},
    '{8'h47, 8'h4E, 8'h47, 8'h47, 8'h41},
    '{8'h47, 8'h50, 8'h52, 8'h4D, 8'h43},
    '{8'h47, 8'h4E, 8'h52, 8'h4D, 8'h43}
  };

  typedef enum logic [2:0] {
    ST_FIX   = 3'd0,
    ST_MIN   = 3'd1,
    ST_UNSUP = 3'd2,
    ST_BAD   = 3'd3,
    ST_OVF   = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    PH_BEFORE_STAR = 5'b00001,
    PH_WANT_HI     = 5'b00010,
    PH_WANT_LO     = 5'b00100,
    PH_DONE        = 5'b01000,
    PH_FAIL        = 5'b10000
  } phase_t;

  typedef struct packed {
    status_t     status;
    logic        talker_gn;
    logic [31:0] count_ok;
    logic [31:0] count_bad_checksum;
    logic [31:0] count_unsupported;
    logic [31:0] count_overflow;
  } result_t;

  // Bit 4 flags a valid hex digit of either case, bits 3:0 hold its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

// ===== hdl/nmea_chk_core.sv =====
// Sentence state, checksum and type matching, and the four running totals.
// Depends on nmea_chk_pkg; instantiated by nmea_sentence_checker_unit.
module nmea_chk_core
  import nmea_chk_pkg::*;
#(
  parameter int MAX_SENTENCE_LEN = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_valid,
  input  logic [7:0] byte_in,
  output logic       res_valid,
  output result_t    res
);

  localparam logic [7:0] LEN_LIMIT = 8'(MAX_SENTENCE_LEN - 1);

  logic        collecting_r, collecting_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  csum_r, csum_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  recv_r, recv_nxt;
  logic [3:0]  tm_r, tm_nxt;
  logic [31:0] ok_r, ok_nxt;
  logic [31:0] bad_r, bad_nxt;
  logic [31:0] unsup_r, unsup_nxt;
  logic [31:0] ovf_r, ovf_nxt;
  logic [4:0]  hex_w;
  logic [2:0]  pos_w;
  status_t     status_w;
  logic        gn_w;

  assign hex_w = hex_decode(byte_in);
  assign pos_w = len_r[2:0] - 3'd1;

  always_comb begin
    collecting_nxt = collecting_r;
    len_nxt        = len_r;
    csum_nxt       = csum_r;
    phase_nxt      = phase_r;
    recv_nxt       = recv_r;
    tm_nxt         = tm_r;
    ok_nxt         = ok_r;
    bad_nxt        = bad_r;
    unsup_nxt      = unsup_r;
    ovf_nxt        = ovf_r;
    res_valid      = 1'b0;
    status_w       = ST_BAD;
    gn_w           = 1'b0;
    if (byte_valid) begin
      if (byte_in == CH_DOLLAR) begin
        collecting_nxt = 1'b1;
        len_nxt        = 8'd1;
        csum_nxt       = 8'd0;
        phase_nxt      = PH_BEFORE_STAR;
        recv_nxt       = 8'd0;
        tm_nxt         = 4'hF;
      end else if (collecting_r) begin
        if (byte_in == CH_CR || byte_in == CH_LF) begin
          collecting_nxt = 1'b0;
          len_nxt        = 8'd0;
          res_valid      = 1'b1;
          if (phase_r != PH_DONE || csum_r != recv_r) begin
            bad_nxt  = bad_r + 32'd1;
            status_w = ST_BAD;
          end else if (|tm_r[1:0]) begin
            ok_nxt   = ok_r + 32'd1;
            status_w = ST_FIX;
            gn_w     = tm_r[1];
          end else if (|tm_r[3:2]) begin
            ok_nxt   = ok_r + 32'd1;
            status_w = ST_MIN;
            gn_w     = tm_r[3];
          end else begin
            unsup_nxt = unsup_r + 32'd1;
            status_w  = ST_UNSUP;
          end
        end else if (len_r >= LEN_LIMIT) begin
          collecting_nxt = 1'b0;
          len_nxt        = 8'd0;
          res_valid      = 1'b1;
          ovf_nxt        = ovf_r + 32'd1;
          status_w       = ST_OVF;
        end else begin
          len_nxt = len_r + 8'd1;
          // Only the five name characters and the delimiter after them matter.
          if (len_r >= 8'd1 && len_r <= 8'd5) begin
            for (int k = 0; k < NUM_TYPES; k++) begin
              if (TYPE_NAMES[k][pos_w] != byte_in) begin
                tm_nxt[k] = 1'b0;
              end
            end
          end else if (len_r == 8'd6) begin
            if (byte_in != CH_COMMA && byte_in != CH_STAR) begin
              tm_nxt = 4'h0;
            end
          end
          case (phase_r)
            PH_BEFORE_STAR: begin
              if (byte_in == CH_NUL) begin
                phase_nxt = PH_FAIL;
              end else if (byte_in == CH_STAR) begin
                phase_nxt = PH_WANT_HI;
              end else begin
                csum_nxt = csum_r ^ byte_in;
              end
            end
            PH_WANT_HI: begin
              if (!hex_w[4]) begin
                phase_nxt = PH_FAIL;
              end else begin
                recv_nxt  = {hex_w[3:0], 4'h0};
                phase_nxt = PH_WANT_LO;
              end
            end
            PH_WANT_LO: begin
              if (!hex_w[4]) begin
                phase_nxt = PH_FAIL;
              end else begin
                recv_nxt  = {recv_r[7:4], hex_w[3:0]};
                phase_nxt = PH_DONE;
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  assign res.status             = status_w;
  assign res.talker_gn          = gn_w;
  assign res.count_ok           = ok_nxt;
  assign res.count_bad_checksum = bad_nxt;
  assign res.count_unsupported  = unsup_nxt;
  assign res.count_overflow     = ovf_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      len_r        <= 8'd0;
      csum_r       <= 8'd0;
      phase_r      <= PH_BEFORE_STAR;
      recv_r       <= 8'd0;
      tm_r         <= 4'hF;
      ok_r         <= 32'd0;
      bad_r        <= 32'd0;
      unsup_r      <= 32'd0;
      ovf_r        <= 32'd0;
    end else begin
      collecting_r <= collecting_nxt;
      len_r        <= len_nxt;
      csum_r       <= csum_nxt;
      phase_r      <= phase_nxt;
      recv_r       <= recv_nxt;
      tm_r         <= tm_nxt;
      ok_r         <= ok_nxt;
      bad_r        <= bad_nxt;
      unsup_r      <= unsup_nxt;
      ovf_r        <= ovf_nxt;
    end
  end

endmodule

// ===== hdl/nmea_sentence_checker_unit.sv =====
// Top level of the NMEA sentence checker: input register, core and result register.
// Depends on nmea_chk_pkg and nmea_chk_core.
//
//   Channel   Direction  Handshake           Payload
//   in_       input      in_valid/in_stall   in_data_byte[7:0]
//   out_      output     out_valid/out_stall out_status, out_talker_gn, four 32-bit counts
//
// A byte is processed during the cycle it sits in the input register, and its result is
// loaded into the output register on the edge that moves the byte on. The byte that ends a
// sentence is therefore held in the input register and its result then in the output register,
// and one byte is taken every cycle while the output side keeps up. The input stall rises only while the
// output register holds a result that is being stalled. Reset is synchronous and
// active low; it clears the sentence state and all four totals.
module nmea_sentence_checker_unit
  import nmea_chk_pkg::*;
#(
  parameter int MAX_SENTENCE_LEN = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic        out_talker_gn,
  output logic [31:0] out_count_ok,
  output logic [31:0] out_count_bad_checksum,
  output logic [31:0] out_count_unsupported,
  output logic [31:0] out_count_overflow
);

  // Input register holding one received byte.
  logic       a_valid_r, a_valid_nxt;
  logic [7:0] a_byte_r;
  // Output register holding one finished result.
  logic       out_valid_r, out_valid_nxt;
  result_t    out_res_r;

  logic       a_adv;
  logic       in_take;
  logic       res_valid;
  result_t    res;

  // The held byte moves on when the result register is free or is being
  // drained in this cycle, so a byte that moves on always finds room for its result.
  assign a_adv    = !out_valid_r || !out_stall;
  assign in_stall = a_valid_r && !a_adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (in_take) begin
      a_valid_nxt = 1'b1;
    end else if (a_adv) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_byte_r <= in_data_byte;
    end
  end

  nmea_chk_core #(
    .MAX_SENTENCE_LEN(MAX_SENTENCE_LEN)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_valid(a_valid_r && a_adv),
    .byte_in   (a_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // A new result can only arrive when a_adv holds, which means the register is
  // empty or its current result is transferred on this same edge.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_res_r.status;
  assign out_talker_gn          = out_res_r.talker_gn;
  assign out_count_ok           = out_res_r.count_ok;
  assign out_count_bad_checksum = out_res_r.count_bad_checksum;
  assign out_count_unsupported  = out_res_r.count_unsupported;
  assign out_count_overflow     = out_res_r.count_overflow;

endmodule

// ===== hdl/nmea_chk_checker.sv =====
// Port-level checker for the NMEA sentence checker unit, bound to the top level.
// Depends on nmea_chk_pkg and nmea_sentence_checker_unit_macros.svh.
`include "nmea_sentence_checker_unit_macros.svh"

module nmea_chk_checker
  import nmea_chk_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic        out_talker_gn,
  input logic [31:0] out_count_ok,
  input logic [31:0] out_count_overflow
);

  // A stalled result stays on the port; its status and OK count do not change.
  `NSC_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_count_ok) && $stable(out_status))

  // Only the five defined status codes ever leave the block.
  `NSC_ASSERT_IMPLIES(a_status_range, clk, rst_n, out_valid, out_status <= ST_OVF)

  // The talker flag is only meaningful for accepted sentences.
  `NSC_ASSERT_IMPLIES(a_talker_zero, clk, rst_n, out_valid && (out_status == ST_UNSUP || out_status == ST_BAD || out_status == ST_OVF), !out_talker_gn)

  // Input is only held back while a result is waiting on a stalled output.
  `NSC_ASSERT_IMPLIES(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

  // Consecutive results with an unchanged overflow count cannot be an overflow.
  `NSC_ASSERT_NEXT(a_ovf_count, clk, rst_n, out_valid && !out_stall && in_valid && !in_stall, !out_valid || out_status != ST_OVF || out_count_overflow != $past(out_count_overflow))

endmodule

bind nmea_sentence_checker_unit nmea_chk_checker u_nmea_chk_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_talker_gn     (out_talker_gn),
  .out_count_ok      (out_count_ok),
  .out_count_overflow(out_count_overflow)
);
